[hw/rtl/vnpg_pkg.sv]
package vnpg_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int PIXEL_W   = 16;
  localparam int LEVEL_W   = 20;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_FRAC = 20;
  localparam int MIX_SHIFT = 33;

  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd3;

  localparam logic [63:0] SEED_RST = 64'd0;
  localparam logic [31:0] STEP_RST = 32'd32768;
  localparam logic [15:0] GAIN_RST = 16'd4096;

  localparam logic [31:0] HASH_KX  = 32'd2654435761;
  localparam logic [31:0] HASH_KY  = 32'd2246822519;
  localparam logic [63:0] MIX_C1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] WORD_MAX = 32'hFFFFFFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 20'hFFFFF;

  // Register stages inside each unit.
  localparam int HASH_LAT  = 7;
  localparam int BLEND_LAT = 6;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] grey_level;
    logic               saturated;
  } pix_out_t;

endpackage

[hw/rtl/vnpg_hash.sv]
module vnpg_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [63:0]          seed,
  input  logic [31:0]          cx,
  input  logic [31:0]          cy,
  output logic [FRAC_BITS:0]   cval
);
  import vnpg_pkg::*;

  logic [63:0] px, py, v1, p0a, p0b, v2, v3;
  logic [31:0] p1a, p2a, p1b, p2b, x;
  logic [63:0] key, s1, s2, m0a, m1a, m2a, m0b, m1b, m2b;
  logic [31+FRAC_BITS:0] y;
  logic [FRAC_BITS-1:0]  q0;
  logic [32:0]           r;

  assign key = seed ^ px ^ py;
  assign m0a = 64'(v1[31:0]) * 64'(MIX_C1[31:0]);
  assign m1a = 64'(v1[63:32]) * 64'(MIX_C1[31:0]);
  assign m2a = 64'(v1[31:0]) * 64'(MIX_C1[63:32]);
  // Only the low 64 bits of the full product matter.
  assign s1  = p0a + {p1a + p2a, 32'd0};
  assign m0b = 64'(v2[31:0]) * 64'(MIX_C2[31:0]);
  assign m1b = 64'(v2[63:32]) * 64'(MIX_C2[31:0]);
  assign m2b = 64'(v2[31:0]) * 64'(MIX_C2[63:32]);
  assign s2  = p0b + {p1b + p2b, 32'd0};

  // Division by 2^32-1: quotient estimate from the high bits, one correction.
  assign y  = {x, {FRAC_BITS{1'b0}}};
  assign q0 = y[31+FRAC_BITS:32];
  assign r  = 33'(y[31:0]) + 33'(q0);

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= 64'(cx) * 64'(HASH_KX);
      py   <= 64'(cy) * 64'(HASH_KY);
      v1   <= key ^ (key >> MIX_SHIFT);
      p0a  <= m0a;
      p1a  <= m1a[31:0];
      p2a  <= m2a[31:0];
      v2   <= s1 ^ (s1 >> MIX_SHIFT);
      p0b  <= m0b;
      p1b  <= m1b[31:0];
      p2b  <= m2b[31:0];
      v3   <= s2 ^ (s2 >> MIX_SHIFT);
      cval <= (FRAC_BITS+1)'(q0) + (FRAC_BITS+1)'(r >= 33'(WORD_MAX));
    end
  end

  assign x = v3[31:0];

endmodule

[hw/rtl/vnpg_blend.sv]
module vnpg_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [FRAC_BITS:0]     ca,
  input  logic [FRAC_BITS:0]     cb,
  input  logic [FRAC_BITS:0]     cc,
  input  logic [FRAC_BITS:0]     cd,
  input  logic [FRAC_BITS+1:0]   ux,
  input  logic [FRAC_BITS+1:0]   uy,
  input  logic [15:0]            gain,
  output vnpg_pkg::pix_out_t     result
);
  import vnpg_pkg::*;

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 1 + UW;
  localparam int LW = UW + 16 - (FRAC_BITS - 4);
  localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

  logic [PW-1:0]   pa, pb, pc, pd, pt, pl;
  logic [PW:0]     st, sb, sn;
  logic [UW-1:0]   uy1, uy2, top, bot, n;
  logic [UW+15:0]  ng;
  logic [LW-1:0]   level;

  assign st    = (PW+1)'(pa) + (PW+1)'(pb);
  assign sb    = (PW+1)'(pc) + (PW+1)'(pd);
  assign sn    = (PW+1)'(pt) + (PW+1)'(pl);
  assign level = ng[UW+15:FRAC_BITS-4];

  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= PW'((ONE - ux) * PW'(ca));
      pb  <= PW'(ux * PW'(cb));
      pc  <= PW'((ONE - ux) * PW'(cc));
      pd  <= PW'(ux * PW'(cd));
      uy1 <= uy;
      top <= UW'(st >> FRAC_BITS);
      bot <= UW'(sb >> FRAC_BITS);
      uy2 <= uy1;
      pt  <= PW'(PW'(top) * PW'(ONE - uy2));
      pl  <= PW'(PW'(bot) * PW'(uy2));
      n   <= UW'(sn >> FRAC_BITS);
      ng  <= (UW+16)'(n) * (UW+16)'(gain);
      if (level > LW'(LEVEL_MAX)) begin
        result.grey_level <= LEVEL_MAX;
        result.saturated  <= 1'b1;
      end else begin
        result.grey_level <= LEVEL_W'(level);
        result.saturated  <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/value_noise_pixel_generator_top.sv]
// Value noise pixel generator.
// Input channel in_valid/in_ready carries one pixel request (pixel_x, pixel_y);
// output channel out_valid/out_ready returns the grey level and a flag set
// when the level was clipped to its maximum.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 seed,
// 1 step_x, 2 step_y, 3 gain. The user must write them only while no request
// is in flight; the block does not enforce this.
// Stages: one for the lattice position multiply, seven in each corner hash (two
// 64-bit multiplies split into 32-bit partial products) and six in the blend.
// One request is accepted every cycle unless the receiver stalls; all four
// corner hashes run in parallel. When the receiver stalls, the whole pipeline
// holds and in_ready falls only while the output register holds an untaken
// result. Synchronous reset empties the pipeline and loads the default
// registers: seed 0, both steps 0.03125 and unity gain.
module value_noise_pixel_generator_top #(
  parameter int COORD_BITS = vnpg_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = vnpg_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vnpg_pkg::pix_in_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vnpg_pkg::pix_out_t                out_data,
  input  logic                              cfg_we,
  input  logic [vnpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vnpg_pkg::CFG_W-1:0]        cfg_data
);
  import vnpg_pkg::*;

  localparam int PW    = COORD_BITS + 32;
  localparam int UW    = FRAC_BITS + 2;
  localparam int DEPTH = 1 + HASH_LAT + BLEND_LAT;
  localparam int UDLY  = HASH_LAT - 2;

  logic [63:0] seed;
  logic [31:0] step_x, step_y;
  logic [15:0] gain;
  logic        en;
  logic [DEPTH-1:0] vld;

  logic [PW-1:0]        pos_x, pos_y;
  logic [31:0]          cx, cy, nx, ny;
  logic [23:0]          f24x, f24y;
  logic [FRAC_BITS-1:0] fx, fy, sqx, sqy;
  logic [2*FRAC_BITS-1:0] ffx, ffy;
  logic [UW-1:0]        tx, ty, ux, uy;
  logic [2*FRAC_BITS+1:0] smx, smy;
  logic [UW-1:0]        udx [UDLY];
  logic [UW-1:0]        udy [UDLY];
  logic [FRAC_BITS:0]   ca, cb, cc, cd;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed   <= SEED_RST;
      step_x <= STEP_RST;
      step_y <= STEP_RST;
      gain   <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:   seed   <= cfg_data;
        REG_STEP_X: step_x <= cfg_data[31:0];
        REG_STEP_Y: step_y <= cfg_data[31:0];
        REG_GAIN:   gain   <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Cell index and fraction of each axis from the lattice position.
  assign cx   = 32'(pos_x[PW-1:STEP_FRAC]);
  assign cy   = 32'(pos_y[PW-1:STEP_FRAC]);
  assign nx   = cx + 32'd1;
  assign ny   = cy + 32'd1;
  assign f24x = {pos_x[STEP_FRAC-1:0], 4'd0};
  assign f24y = {pos_y[STEP_FRAC-1:0], 4'd0};
  assign fx   = FRAC_BITS'(f24x >> (24 - FRAC_BITS));
  assign fy   = FRAC_BITS'(f24y >> (24 - FRAC_BITS));
  assign ffx  = (2*FRAC_BITS)'(fx) * (2*FRAC_BITS)'(fx);
  assign ffy  = (2*FRAC_BITS)'(fy) * (2*FRAC_BITS)'(fy);
  assign smx  = (2*FRAC_BITS+2)'(sqx) * (2*FRAC_BITS+2)'(tx);
  assign smy  = (2*FRAC_BITS+2)'(sqy) * (2*FRAC_BITS+2)'(ty);

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= PW'(in_data.pixel_x[COORD_BITS-1:0]) * PW'(step_x);
      pos_y <= PW'(in_data.pixel_y[COORD_BITS-1:0]) * PW'(step_y);
      sqx   <= ffx[2*FRAC_BITS-1:FRAC_BITS];
      sqy   <= ffy[2*FRAC_BITS-1:FRAC_BITS];
      tx    <= (UW'(3) << FRAC_BITS) - UW'({fx, 1'b0});
      ty    <= (UW'(3) << FRAC_BITS) - UW'({fy, 1'b0});
      ux    <= smx[2*FRAC_BITS+1:FRAC_BITS];
      uy    <= smy[2*FRAC_BITS+1:FRAC_BITS];
      udx[0] <= ux;
      udy[0] <= uy;
      for (int i = 1; i < UDLY; i++) begin
        udx[i] <= udx[i-1];
        udy[i] <= udy[i-1];
      end
    end
  end

  vnpg_hash #(.FRAC_BITS(FRAC_BITS)) u_hash_a (
    .clk(clk), .en(en), .seed(seed), .cx(cx), .cy(cy), .cval(ca));
  vnpg_hash #(.FRAC_BITS(FRAC_BITS)) u_hash_b (
    .clk(clk), .en(en), .seed(seed), .cx(nx), .cy(cy), .cval(cb));
  vnpg_hash #(.FRAC_BITS(FRAC_BITS)) u_hash_c (
    .clk(clk), .en(en), .seed(seed), .cx(cx), .cy(ny), .cval(cc));
  vnpg_hash #(.FRAC_BITS(FRAC_BITS)) u_hash_d (
    .clk(clk), .en(en), .seed(seed), .cx(nx), .cy(ny), .cval(cd));

  vnpg_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk(clk), .en(en),
    .ca(ca), .cb(cb), .cc(cc), .cd(cd),
    .ux(udx[UDLY-1]), .uy(udy[UDLY-1]),
    .gain(gain), .result(out_data));

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.grey_level == LEVEL_MAX)
    else $error("saturated result below maximum");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

endmodule

[tb/value_noise_pixel_generator_top_test.sv]
`timescale 1ns / 100ps

module value_noise_pixel_generator_top_test;
  import vnpg_pkg::*;

  localparam int FB = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int RX_HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEED;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [63:0] seed_q;
  logic [31:0] stepx_q, stepy_q;
  logic [15:0] gain_q;

  pix_out_t pending_levels[$];
  int errors = 0;
  bit rx_idle_on = 1'b1;
  bit tx_idle_on = 1'b1;
  int hold_requests = 0;
  int hold_taken = 0;
  int rx_hold = 0;

  value_noise_pixel_generator_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] corner_level(logic [31:0] cx, logic [31:0] cy);
    logic [63:0] v;
    logic [127:0] q;
    v = seed_q ^ (64'(cx) * 64'(HASH_KX)) ^ (64'(cy) * 64'(HASH_KY));
    v = v ^ (v >> 33);
    v = v * MIX_C1;
    v = v ^ (v >> 33);
    v = v * MIX_C2;
    v = v ^ (v >> 33);
    q = (128'(v[31:0]) << FB) / 128'(WORD_MAX);
    return q[63:0];
  endfunction

  function automatic logic [63:0] smoothstep(logic [63:0] f);
    logic [63:0] sq;
    sq = (f * f) >> FB;
    return (sq * ((64'd3 << FB) - 2 * f)) >> FB;
  endfunction

  function automatic pix_out_t noise_level(pix_in_t p);
    logic [63:0] px, py, fx, fy, ux, uy, a, b, c, d, top, bot, n, lvl, one;
    logic [31:0] cx, cy;
    pix_out_t r;
    one = 64'd1 << FB;
    px = 64'(p.pixel_x) * 64'(stepx_q);
    py = 64'(p.pixel_y) * 64'(stepy_q);
    cx = px[51:20];
    cy = py[51:20];
    fx = (64'(px[19:0]) << 4) >> (24 - FB);
    fy = (64'(py[19:0]) << 4) >> (24 - FB);
    ux = smoothstep(fx);
    uy = smoothstep(fy);
    a = corner_level(cx, cy);
    b = corner_level(cx + 32'd1, cy);
    c = corner_level(cx, cy + 32'd1);
    d = corner_level(cx + 32'd1, cy + 32'd1);
    top = (a * (one - ux) + b * ux) >> FB;
    bot = (c * (one - ux) + d * ux) >> FB;
    n = (top * (one - uy) + bot * uy) >> FB;
    lvl = (n * 64'(gain_q)) >> (FB - 4);
    r.saturated = lvl > 64'(LEVEL_MAX);
    r.grey_level = r.saturated ? LEVEL_MAX : lvl[LEVEL_W-1:0];
    return r;
  endfunction

  // Request sender: valid is held with a steady payload until accepted, and
  // only dropped while idling so that requests can follow back to back.
  task automatic send_pixel(logic [15:0] x, logic [15:0] y);
    pix_in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    while (tx_idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    pending_levels = {pending_levels, noise_level(p)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SEED: seed_q = val;
      REG_STEP_X: stepx_q = val[31:0];
      REG_STEP_Y: stepy_q = val[31:0];
      default: gain_q = val[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [63:0] s, logic [31:0] sx, logic [31:0] sy,
                            logic [15:0] g);
    wait_drained();
    write_reg(REG_SEED, s);
    write_reg(REG_STEP_X, {$urandom, sx});
    write_reg(REG_STEP_Y, {$urandom, sy});
    write_reg(REG_GAIN, {$urandom, 16'($urandom_range(65535)), g});
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'hAAAA, 16'h5555);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'd31, 16'd32);
    send_pixel(16'd33, 16'd1);
  endtask

  task automatic test_register_settings();
    set_config({$urandom, $urandom}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    test_directed_extremes();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 16'hFFFF);
    send_pixel(16'd7, 16'd9);
    send_pixel(16'hFFFF, 16'h1234);
    // Full gain scales samples up to just under the maximum level, without clipping.
    set_config({$urandom, $urandom}, 32'h0008_0000, 32'h0001_8000, 16'hFFFF);
    repeat (6) send_pixel(16'($urandom), 16'($urandom));
    set_config(64'd0, 32'h0010_0000, 32'h0000_0001, 16'd0);
    send_pixel(16'd3, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd3);
  endtask

  task automatic test_random_pixels();
    int unsigned sel;
    for (int ph = 0; ph < 6; ph++) begin
      sel = $urandom_range(2);
      set_config({$urandom, $urandom},
                 sel == 0 ? $urandom_range(32'h4_0000) : $urandom,
                 sel == 1 ? $urandom_range(32'h4_0000) : $urandom,
                 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(16'h1800)));
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      for (int k = 0; k < 250; k++) send_pixel(16'($urandom), 16'($urandom));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int k = 0; k < 40; k++) send_pixel(16'($urandom), 16'($urandom));
    wait_drained();
    for (int k = 0; k < 10; k++) send_pixel(16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (hold_taken != hold_requests) begin
      hold_taken <= hold_requests;
      rx_hold <= RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 13);
    end
  end

  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected level %h", $time, out_data);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (out_data.grey_level !== want.grey_level) begin
          $display("%0t: grey_level expected %h actual %h", $time, want.grey_level,
                   out_data.grey_level);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_data.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    seed_q = SEED_RST;
    stepx_q = STEP_RST;
    stepy_q = STEP_RST;
    gain_q = GAIN_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_register_settings();
    test_backpressure();
    test_random_pixels();
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
